@@ design/ihss_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ihss_pkg - shared types and constants of the image header size sniffer
// Parser phases, status codes, configuration indexes and header tables.
// ----------------------------------------------------------------------------
package ihss_pkg;

	// Format mode codes
	localparam logic [1:0] MODE_PNG  = 2'd0;
	localparam logic [1:0] MODE_GIF  = 2'd1;
	localparam logic [1:0] MODE_JPEG = 2'd2;

	// Configuration register indexes
	localparam logic CFG_FORMAT_MODE = 1'b0;
	localparam logic CFG_BYTE_LIMIT  = 1'b1;

	localparam logic [15:0] BYTE_LIMIT_RESET = 16'd8196;

	// JPEG marker bytes
	localparam logic [7:0] JPG_FF  = 8'hFF;
	localparam logic [7:0] JPG_SOI = 8'hD8;
	localparam logic [7:0] JPG_RST_LO = 8'hD0;
	localparam logic [7:0] JPG_RST_HI = 8'hD9;
	localparam logic [7:0] JPG_STUFF  = 8'h00;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_PNG,
		PH_GIF,
		PH_JSOI,
		PH_JSEEK,
		PH_JMARK,
		PH_JLENHI,
		PH_JLENLO,
		PH_JSKIP,
		PH_JSOF
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADSIG = 2'd1,
		ST_SHORT  = 2'd2,
		ST_BADLEN = 2'd3
	} status_t;

	// Parser state held between bytes
	typedef struct packed {
		phase_t      phase;
		logic [15:0] skip;
		logic [2:0]  shift;
		logic [7:0]  marker;
		logic [15:0] fw;
		logic [15:0] fh;
	} parse_state_t;

	// Result decision of one byte
	typedef struct packed {
		logic    valid;
		status_t status;
	} parse_res_t;

	// PNG signature and IHDR tag (bytes 8..11 are the chunk length, unchecked)
	function automatic logic [7:0] png_head(input logic [3:0] idx);
		logic [7:0] v;
		case (idx)
			4'd0:    v = 8'h89;
			4'd1:    v = 8'h50;
			4'd2:    v = 8'h4E;
			4'd3:    v = 8'h47;
			4'd4:    v = 8'h0D;
			4'd5:    v = 8'h0A;
			4'd6:    v = 8'h1A;
			4'd7:    v = 8'h0A;
			4'd12:   v = 8'h49;
			4'd13:   v = 8'h48;
			4'd14:   v = 8'h44;
			4'd15:   v = 8'h52;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	// GIF signature; the version digit at byte 4 may be 7 or 9
	function automatic logic gif_ok(input logic [2:0] idx, input logic [7:0] b);
		logic ok;
		case (idx)
			3'd0:    ok = (b == 8'h47);
			3'd1:    ok = (b == 8'h49);
			3'd2:    ok = (b == 8'h46);
			3'd3:    ok = (b == 8'h38);
			3'd4:    ok = (b == 8'h37) || (b == 8'h39);
			3'd5:    ok = (b == 8'h61);
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	// Start-of-frame markers: C0..CF less DHT, JPG and DAC
	function automatic logic is_sof(input logic [7:0] m);
		return (m[7:4] == 4'hC) && (m != 8'hC4) && (m != 8'hC8) && (m != 8'hCC);
	endfunction

endpackage
`default_nettype wire

@@ design/ihss_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ihss_parser - per-byte header parser
// Works out the next parser state and any result for one file byte.
// ----------------------------------------------------------------------------
module ihss_parser #(
	parameter int POS_BITS = 16
) (
	input  wire logic [7:0]           data_b,
	input  wire logic                 first,
	input  wire logic                 last,
	input  wire logic [1:0]           mode,
	input  wire logic [15:0]          limit,
	input  wire ihss_pkg::parse_state_t st,
	input  wire logic [POS_BITS-1:0]  pos,
	output ihss_pkg::parse_state_t    nxt,
	output logic [POS_BITS-1:0]       pos_nxt,
	output ihss_pkg::parse_res_t      res
);
	import ihss_pkg::*;

	localparam int LIM_W = (POS_BITS > 16) ? POS_BITS : 16;

	parse_state_t          eff;
	logic [POS_BITS-1:0]   p;
	logic                  mode_bad;
	logic                  at_limit;
	logic [15:0]           seg_len;

	// Restart on a first byte
	always_comb begin
		eff      = st;
		p        = pos;
		mode_bad = 1'b0;
		if (first) begin
			eff = '0;
			p   = '0;
			case (mode)
				MODE_PNG:  eff.phase = PH_PNG;
				MODE_GIF:  eff.phase = PH_GIF;
				MODE_JPEG: eff.phase = PH_JSOI;
				default: begin
					eff.phase = PH_IDLE;
					mode_bad  = 1'b1;
				end
			endcase
		end
	end

	assign at_limit = LIM_W'(p) >= LIM_W'(limit);
	assign seg_len  = {eff.skip[15:8], data_b};

	// Result decision
	always_comb begin
		res.valid  = 1'b0;
		res.status = ST_OK;
		if (mode_bad) begin
			res.valid  = 1'b1;
			res.status = ST_BADSIG;
		end else begin
			unique case (eff.phase)
				PH_IDLE: ;
				PH_PNG: begin
					if (p < POS_BITS'(16)) begin
						if ((p < POS_BITS'(8) || p >= POS_BITS'(12)) &&
						    data_b != png_head(p[3:0])) begin
							res.valid  = 1'b1;
							res.status = ST_BADSIG;
						end
					end else if (p == POS_BITS'(23)) begin
						res.valid = 1'b1;
					end
				end
				PH_GIF: begin
					if (p < POS_BITS'(6)) begin
						if (!gif_ok(p[2:0], data_b)) begin
							res.valid  = 1'b1;
							res.status = ST_BADSIG;
						end
					end else if (p == POS_BITS'(9)) begin
						res.valid = 1'b1;
					end
				end
				PH_JSOI, PH_JSEEK, PH_JMARK, PH_JLENHI, PH_JLENLO, PH_JSKIP,
				PH_JSOF: begin
					if (at_limit) begin
						res.valid  = 1'b1;
						res.status = ST_SHORT;
					end else if (eff.phase == PH_JSOI) begin
						if ((p == '0) ? (data_b != JPG_FF) : (data_b != JPG_SOI)) begin
							res.valid  = 1'b1;
							res.status = ST_BADSIG;
						end
					end else if (eff.phase == PH_JLENLO) begin
						if (seg_len < 16'd2) begin
							res.valid  = 1'b1;
							res.status = ST_BADLEN;
						end
					end else if (eff.phase == PH_JSOF && eff.shift == 3'd4) begin
						res.valid = 1'b1;
					end
				end
				default: ;
			endcase
			// file ended before the size turned up
			if (!res.valid && eff.phase != PH_IDLE && last) begin
				res.valid  = 1'b1;
				res.status = ST_SHORT;
			end
		end
	end

	// Next state
	always_comb begin
		nxt     = eff;
		pos_nxt = p;
		unique case (eff.phase)
			PH_IDLE: ;
			PH_PNG: begin
				if (p == POS_BITS'(18)) nxt.fw = {data_b, 8'h00};
				else if (p == POS_BITS'(19)) nxt.fw[7:0] = data_b;
				else if (p == POS_BITS'(22)) nxt.fh = {data_b, 8'h00};
				else if (p == POS_BITS'(23)) nxt.fh[7:0] = data_b;
			end
			PH_GIF: begin
				if (p == POS_BITS'(6)) nxt.fw = {8'h00, data_b};
				else if (p == POS_BITS'(7)) nxt.fw[15:8] = data_b;
				else if (p == POS_BITS'(8)) nxt.fh = {8'h00, data_b};
				else if (p == POS_BITS'(9)) nxt.fh[15:8] = data_b;
			end
			PH_JSOI: begin
				if (p != '0) nxt.phase = PH_JSEEK;
			end
			PH_JSEEK: begin
				if (data_b == JPG_FF) nxt.phase = PH_JMARK;
			end
			PH_JMARK: begin
				if (data_b == JPG_FF) begin
					nxt.phase = PH_JMARK;
				end else if ((data_b >= JPG_RST_LO && data_b <= JPG_RST_HI) ||
				             data_b == JPG_STUFF) begin
					nxt.phase = PH_JSEEK;
				end else begin
					nxt.marker = data_b;
					nxt.phase  = PH_JLENHI;
				end
			end
			PH_JLENHI: begin
				nxt.skip  = {data_b, 8'h00};
				nxt.phase = PH_JLENLO;
			end
			PH_JLENLO: begin
				if (is_sof(eff.marker)) begin
					nxt.skip  = seg_len;
					nxt.shift = 3'd0;
					nxt.phase = PH_JSOF;
				end else begin
					nxt.skip  = seg_len - 16'd2;
					nxt.phase = (seg_len == 16'd2) ? PH_JSEEK : PH_JSKIP;
				end
			end
			PH_JSKIP: begin
				nxt.skip = eff.skip - 16'd1;
				if (eff.skip == 16'd1) nxt.phase = PH_JSEEK;
			end
			PH_JSOF: begin
				case (eff.shift)
					3'd1:    nxt.fh = {data_b, 8'h00};
					3'd2:    nxt.fh[7:0] = data_b;
					3'd3:    nxt.fw = {data_b, 8'h00};
					3'd4:    nxt.fw[7:0] = data_b;
					default: ;
				endcase
				nxt.shift = eff.shift + 3'd1;
			end
			default: ;
		endcase
		// saturating position count of an open file
		if (eff.phase != PH_IDLE && p != '1) pos_nxt = p + POS_BITS'(1);
		if (res.valid) nxt.phase = PH_IDLE;
	end

endmodule
`default_nettype wire

@@ design/image_header_size_sniffer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// image_header_size_sniffer - PNG / GIF / JPEG header dimension extractor
// Streams file bytes and returns one status, width and height per file.
// ----------------------------------------------------------------------------
//  channel  signals                                   direction
//  in       in_valid in_ready data_byte first_byte     into block
//           last_byte
//  out      out_valid out_ready status width height    out of block
//  cfg      cfg_we cfg_index cfg_data                  into block
//
// One byte per cycle while results are taken: a byte sits in the input
// register, where the parser decides on it, then any result enters the
// output register. A stalled result holds the input register; a further
// byte is still taken when the input register empties in the same cycle.
// Reset clears the parser to idle; bytes without first_byte are dropped
// when no file is open.
// ----------------------------------------------------------------------------
module image_header_size_sniffer #(
	parameter int POSITION_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        first_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [15:0]      width,
	output logic [15:0]      height,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);
	import ihss_pkg::*;

	logic [1:0]               format_mode_q;
	logic [15:0]              byte_limit_q;

	logic                     v_s1;
	logic [7:0]               data_s1;
	logic                     first_s1;
	logic                     last_s1;

	parse_state_t             st_q;
	logic [POSITION_BITS-1:0] pos_q;
	parse_state_t             st_nxt;
	logic [POSITION_BITS-1:0] pos_nxt;
	parse_res_t               res;

	logic                     adv;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_mode_q <= MODE_PNG;
			byte_limit_q  <= BYTE_LIMIT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_FORMAT_MODE) format_mode_q <= cfg_data[1:0];
			else byte_limit_q <= cfg_data;
		end
	end

	// Input register advances when the output register can take a result
	assign adv      = v_s1 && (!out_valid || out_ready);
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1  <= data_byte;
			first_s1 <= first_byte;
			last_s1  <= last_byte;
		end
	end

	ihss_parser #(
		.POS_BITS (POSITION_BITS)
	) u_parser (
		.data_b  (data_s1),
		.first   (first_s1),
		.last    (last_s1),
		.mode    (format_mode_q),
		.limit   (byte_limit_q),
		.st      (st_q),
		.pos     (pos_q),
		.nxt     (st_nxt),
		.pos_nxt (pos_nxt),
		.res     (res)
	);

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			pos_q <= '0;
		end else if (adv) begin
			st_q  <= st_nxt;
			pos_q <= pos_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv && res.valid) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			status <= res.status;
			width  <= (res.status == ST_OK) ? st_nxt.fw : 16'd0;
			height <= (res.status == ST_OK) ? st_nxt.fh : 16'd0;
		end
	end

`ifndef ASSERT_OFF
	// a fresh result only comes from a parsed byte
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !$past(out_valid)) |-> $past(adv && res.valid))
		else $error("result appeared without a parsed byte");

	// sizes are zero on any failure status
	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (width == 16'd0 && height == 16'd0))
		else $error("nonzero size with failure status");

	// a file closes once its result is given
	a_idle_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res.valid) |=> (st_q.phase == PH_IDLE))
		else $error("parser still open after result");

	// a held byte is neither lost nor overwritten
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> (v_s1 && $stable(data_s1) && $stable(first_s1)))
		else $error("held byte changed");

	// frame field counter never runs past the width low byte
	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_JSOF) |-> (st_q.shift <= 3'd4))
		else $error("frame field counter overran");
`endif

endmodule
`default_nettype wire

@@ tb/sv/size_check_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// size_check_pkg - expected-size tracking for the header size sniffer bench
// Mirrors the per-file header parse in software terms and checks each result
// transaction against the oldest expected status, width and height.
// ----------------------------------------------------------------------------
package size_check_pkg;

	import ihss_pkg::*;

	// Spare mode code: the block answers a bad signature at once
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// PNG signature, IHDR chunk length (unchecked) and IHDR tag
	localparam logic [127:0] PNG_PREAMBLE = 128'h89504E47_0D0A1A0A_00000000_49484452;
	// GIF signature; byte 4 may also be a '9'
	localparam logic [47:0]  GIF_SIGNATURE = "GIF87a";

	typedef struct packed {
		status_t     status;
		logic [15:0] width;
		logic [15:0] height;
	} size_entry_t;

	class size_scoreboard;

		// configuration copy
		logic [1:0]  mode;
		logic [15:0] limit;

		// parser copy
		phase_t      phase;
		logic [15:0] pos;
		logic [15:0] skip;
		logic [2:0]  shift;
		logic [7:0]  marker;
		logic [15:0] fw;
		logic [15:0] fh;
		bit          done;

		size_entry_t expected_sizes[$];
		int          faults;

		function new();
			mode   = MODE_PNG;
			limit  = BYTE_LIMIT_RESET;
			phase  = PH_IDLE;
			pos    = '0;
			skip   = '0;
			shift  = '0;
			marker = '0;
			fw     = '0;
			fh     = '0;
			done   = 1'b1;
			faults = 0;
		endfunction

		function void configure(logic [1:0] m, logic [15:0] lim);
			mode  = m;
			limit = lim;
		endfunction

		function int pending();
			return expected_sizes.size();
		endfunction

		// Start-of-frame markers, excluding DHT, JPG and DAC
		function bit frame_marker(logic [7:0] m);
			return m >= 8'hC0 && m <= 8'hCF && m != 8'hC4 && m != 8'hC8 && m != 8'hCC;
		endfunction

		function void close_file(status_t st);
			size_entry_t e;
			e.status = st;
			e.width  = (st == ST_OK) ? fw : 16'd0;
			e.height = (st == ST_OK) ? fh : 16'd0;
			expected_sizes.push_back(e);
			done  = 1'b1;
			phase = PH_IDLE;
		endfunction

		// One byte through the open file; 1 when it closed the file
		function bit parse_byte(logic [7:0] b);
			int p;
			bit sig_ok;
			p = pos;
			case (phase)
				PH_PNG: begin
					if (p < 16) begin
						if ((p < 8 || p >= 12) && b != PNG_PREAMBLE[127 - 8*p -: 8]) begin
							close_file(ST_BADSIG);
							return 1'b1;
						end
					end else if (p == 18) begin
						fw = {b, 8'h00};
					end else if (p == 19) begin
						fw = fw | {8'h00, b};
					end else if (p == 22) begin
						fh = {b, 8'h00};
					end else if (p == 23) begin
						fh = fh | {8'h00, b};
						close_file(ST_OK);
						return 1'b1;
					end
					return 1'b0;
				end
				PH_GIF: begin
					if (p < 6) begin
						if (p == 4)
							sig_ok = (b == "7") || (b == "9");
						else
							sig_ok = (b == GIF_SIGNATURE[47 - 8*p -: 8]);
						if (!sig_ok) begin
							close_file(ST_BADSIG);
							return 1'b1;
						end
					end else if (p == 6) begin
						fw = {8'h00, b};
					end else if (p == 7) begin
						fw = fw | {b, 8'h00};
					end else if (p == 8) begin
						fh = {8'h00, b};
					end else if (p == 9) begin
						fh = fh | {b, 8'h00};
						close_file(ST_OK);
						return 1'b1;
					end
					return 1'b0;
				end
				default: ;
			endcase

			// jpeg: position limit first
			if (pos >= limit) begin
				close_file(ST_SHORT);
				return 1'b1;
			end
			case (phase)
				PH_JSOI: begin
					if (p == 0) begin
						if (b != JPG_FF) begin
							close_file(ST_BADSIG);
							return 1'b1;
						end
					end else begin
						if (b != JPG_SOI) begin
							close_file(ST_BADSIG);
							return 1'b1;
						end
						phase = PH_JSEEK;
					end
				end
				PH_JSEEK: begin
					if (b == JPG_FF)
						phase = PH_JMARK;
				end
				PH_JMARK: begin
					if (b == JPG_FF)
						return 1'b0;
					if ((b >= JPG_RST_LO && b <= JPG_RST_HI) || b == JPG_STUFF) begin
						phase = PH_JSEEK;
					end else begin
						marker = b;
						phase  = PH_JLENHI;
					end
				end
				PH_JLENHI: begin
					skip  = {b, 8'h00};
					phase = PH_JLENLO;
				end
				PH_JLENLO: begin
					skip = skip | {8'h00, b};
					if (skip < 16'd2) begin
						close_file(ST_BADLEN);
						return 1'b1;
					end
					if (frame_marker(marker)) begin
						shift = '0;
						phase = PH_JSOF;
					end else begin
						skip  = skip - 16'd2;
						phase = (skip == 16'd0) ? PH_JSEEK : PH_JSKIP;
					end
				end
				PH_JSKIP: begin
					skip = skip - 16'd1;
					if (skip == 16'd0)
						phase = PH_JSEEK;
				end
				PH_JSOF: begin
					if (shift == 3'd1) begin
						fh = {b, 8'h00};
					end else if (shift == 3'd2) begin
						fh = fh | {8'h00, b};
					end else if (shift == 3'd3) begin
						fw = {b, 8'h00};
					end else if (shift == 3'd4) begin
						fw = fw | {8'h00, b};
						close_file(ST_OK);
						return 1'b1;
					end
					shift = shift + 3'd1;
				end
				default: ;
			endcase
			return 1'b0;
		endfunction

		// Note one accepted input transaction
		function void note_byte(logic [7:0] b, logic is_first, logic is_last);
			if (is_first) begin
				done   = 1'b0;
				pos    = '0;
				skip   = '0;
				shift  = '0;
				marker = '0;
				fw     = '0;
				fh     = '0;
				case (mode)
					MODE_PNG:  phase = PH_PNG;
					MODE_GIF:  phase = PH_GIF;
					MODE_JPEG: phase = PH_JSOI;
					default: begin
						close_file(ST_BADSIG);
						return;
					end
				endcase
			end
			if (done)
				return;
			if (parse_byte(b))
				return;
			if (pos != 16'hFFFF)
				pos = pos + 16'd1;
			if (is_last)
				close_file(ST_SHORT);
		endfunction

		// Check one accepted result transaction against the oldest expectation
		function void check_size(logic [1:0] st, logic [15:0] w, logic [15:0] h);
			size_entry_t e;
			if (expected_sizes.size() == 0) begin
				$error("unexpected result: status %0d width %0d height %0d", st, w, h);
				faults++;
				return;
			end
			e = expected_sizes.pop_front();
			if (st != e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				faults++;
			end
			if (w != e.width) begin
				$error("width: expected %0d, got %0d", e.width, w);
				faults++;
			end
			if (h != e.height) begin
				$error("height: expected %0d, got %0d", e.height, h);
				faults++;
			end
		endfunction

	endclass

endpackage

@@ tb/sv/tb_image_header_size_sniffer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_image_header_size_sniffer - bench for the image header size sniffer
// Streams PNG, GIF and JPEG headers, whole, damaged, cut short or abandoned,
// under several mode and limit settings with random gaps and output stalls,
// and checks every result transaction against a software copy of the parser.
// ----------------------------------------------------------------------------
module tb_image_header_size_sniffer;

	import ihss_pkg::*;
	import size_check_pkg::*;

	typedef enum int {FLAW_NONE, FLAW_SOI, FLAW_LENGTH} flaw_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte  = 8'h00;
	logic        first_byte = 1'b0;
	logic        last_byte  = 1'b0;
	logic        out_valid;
	logic        out_ready  = 1'b0;
	logic [1:0]  status;
	logic [15:0] width;
	logic [15:0] height;
	logic        cfg_we     = 1'b0;
	logic        cfg_index  = 1'b0;
	logic [15:0] cfg_data   = 16'h0000;

	size_scoreboard sb = new();

	logic [7:0]  file_bytes[$];
	logic [1:0]  cur_mode  = MODE_PNG;
	logic [15:0] cur_limit = BYTE_LIMIT_RESET;
	bit          calm      = 1'b0;
	int          random_bytes  = 0;
	int          sizes_checked = 0;

	image_header_size_sniffer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.first_byte(first_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.width     (width),
		.height    (height),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result side back-pressure
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= 21);
	end

	// Transaction monitor
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_byte(data_byte, first_byte, last_byte);
		if (arst_n && out_valid && out_ready) begin
			sb.check_size(status, width, height);
			sizes_checked++;
		end
	end

	// Hard stop
	initial begin
		#24_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Both registers back to back; block must be idle
	task automatic program_regs(input logic [1:0] mode, input logic [15:0] lim);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_FORMAT_MODE;
		cfg_data  <= {14'd0, mode};
		@(posedge clk);
		cfg_index <= CFG_BYTE_LIMIT;
		cfg_data  <= lim;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.configure(mode, lim);
		cur_mode  = mode;
		cur_limit = lim;
	endtask

	// One input transaction; returns at the accepting edge with valid still high
	task automatic put_byte(input logic [7:0] d, input logic is_first, input logic is_last);
		while (!calm && $urandom_range(0, 99) < 21) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= d;
		first_byte <= is_first;
		last_byte  <= is_last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_file(input bit with_last);
		int n;
		n = file_bytes.size();
		for (int i = 0; i < n; i++)
			put_byte(file_bytes[i], i == 0, with_last && i == n - 1);
		random_bytes += n;
	endtask

	// Bytes with no first flag: dropped when no file is open
	task automatic send_stray(input int n);
		repeat (n)
			put_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
	endtask

	// Wait for all expected results, then for the pipeline to empty
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (6)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// File builders
	// ------------------------------------------------------------------

	function automatic void trim_file(input int n);
		while (file_bytes.size() > n)
			void'(file_bytes.pop_back());
	endfunction

	function automatic logic [15:0] rand_size16();
		case ($urandom_range(0, 9))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_size32();
		logic [31:0] r;
		r = $urandom;
		r[15:0] = rand_size16();
		return r;
	endfunction

	function automatic void build_png(input logic [31:0] w, input logic [31:0] h,
			input bit damaged);
		int at;
		file_bytes = {};
		for (int i = 0; i < 16; i++)
			file_bytes.push_back((i >= 8 && i < 12) ? 8'($urandom)
				: PNG_PREAMBLE[127 - 8*i -: 8]);
		for (int i = 3; i >= 0; i--)
			file_bytes.push_back(w[8*i +: 8]);
		for (int i = 3; i >= 0; i--)
			file_bytes.push_back(h[8*i +: 8]);
		repeat ($urandom_range(0, 4))
			file_bytes.push_back(8'($urandom));
		// spoil one checked signature or tag byte
		if (damaged) begin
			at = $urandom_range(0, 11);
			if (at >= 8)
				at += 4;
			file_bytes[at] = file_bytes[at] ^ 8'($urandom_range(1, 255));
		end
	endfunction

	function automatic void build_gif(input logic [15:0] w, input logic [15:0] h,
			input logic [7:0] digit, input bit damaged);
		file_bytes = {};
		for (int i = 0; i < 6; i++)
			file_bytes.push_back((i == 4) ? digit : GIF_SIGNATURE[47 - 8*i -: 8]);
		file_bytes.push_back(w[7:0]);
		file_bytes.push_back(w[15:8]);
		file_bytes.push_back(h[7:0]);
		file_bytes.push_back(h[15:8]);
		repeat ($urandom_range(0, 4))
			file_bytes.push_back(8'($urandom));
		if (damaged)
			file_bytes[$urandom_range(0, 5)] = 8'($urandom);
	endfunction

	// Any marker that carries a length but is not a start of frame
	function automatic logic [7:0] segment_marker();
		case ($urandom_range(0, 3))
			0:       return 8'hC4 + 8'(4 * $urandom_range(0, 2));
			1:       return 8'hE0 + 8'($urandom_range(0, 15));
			2:       return 8'($urandom_range(8'h01, 8'hBF));
			default: return 8'($urandom_range(8'hDA, 8'hFE));
		endcase
	endfunction

	function automatic logic [7:0] frame_code();
		logic [7:0] m;
		do
			m = 8'hC0 + 8'($urandom_range(0, 15));
		while (m == 8'hC4 || m == 8'hC8 || m == 8'hCC);
		return m;
	endfunction

	function automatic void build_jpeg(input logic [15:0] h, input logic [15:0] w,
			input logic [7:0] sof_mk, input int segs, input flaw_t flaw);
		int          body;
		logic [15:0] len;
		file_bytes = {};
		// start of image, possibly broken in either byte
		if (flaw == FLAW_SOI && $urandom_range(0, 1)) begin
			file_bytes.push_back(8'($urandom_range(0, 254)));
			file_bytes.push_back(JPG_SOI);
		end else if (flaw == FLAW_SOI) begin
			file_bytes.push_back(JPG_FF);
			file_bytes.push_back(JPG_SOI ^ 8'($urandom_range(1, 255)));
		end else begin
			file_bytes.push_back(JPG_FF);
			file_bytes.push_back(JPG_SOI);
		end
		repeat (segs) begin
			case ($urandom_range(0, 4))
				0: begin
					// junk between segments
					repeat ($urandom_range(1, 3))
						file_bytes.push_back(8'($urandom_range(0, 254)));
				end
				1: begin
					// fill bytes then a restart marker
					repeat ($urandom_range(2, 4))
						file_bytes.push_back(JPG_FF);
					file_bytes.push_back(8'($urandom_range(JPG_RST_LO, JPG_RST_HI)));
				end
				2: begin
					file_bytes.push_back(JPG_FF);
					file_bytes.push_back(JPG_STUFF);
				end
				default: begin
					body = $urandom_range(0, 6);
					len  = 16'(body + 2);
					// oversized segment runs into a small limit
					if (cur_limit <= 16'd400 && $urandom_range(0, 9) == 0)
						len[15:8] = 8'($urandom_range(1, 255));
					file_bytes.push_back(JPG_FF);
					file_bytes.push_back(segment_marker());
					file_bytes.push_back(len[15:8]);
					file_bytes.push_back(len[7:0]);
					repeat (body)
						file_bytes.push_back(8'($urandom));
				end
			endcase
		end
		if (flaw == FLAW_LENGTH) begin
			file_bytes.push_back(JPG_FF);
			file_bytes.push_back($urandom_range(0, 1) ? frame_code() : segment_marker());
			file_bytes.push_back(8'h00);
			file_bytes.push_back(8'($urandom_range(0, 1)));
		end
		// start of frame: length, precision, height, width
		len = 16'($urandom_range(8, 17));
		file_bytes.push_back(JPG_FF);
		file_bytes.push_back(sof_mk);
		file_bytes.push_back(len[15:8]);
		file_bytes.push_back(len[7:0]);
		file_bytes.push_back(8'($urandom));
		file_bytes.push_back(h[15:8]);
		file_bytes.push_back(h[7:0]);
		file_bytes.push_back(w[15:8]);
		file_bytes.push_back(w[7:0]);
		repeat ($urandom_range(0, 3))
			file_bytes.push_back(8'($urandom));
	endfunction

	// One random file, mostly of the configured format
	task automatic random_file();
		logic [1:0] kind;
		logic [7:0] digit;
		int         pick;
		flaw_t      flaw;
		kind = cur_mode;
		if (cur_mode == MODE_UNUSED || $urandom_range(0, 99) < 20)
			kind = 2'($urandom_range(0, 2));
		case (kind)
			MODE_PNG: begin
				build_png(rand_size32(), rand_size32(), $urandom_range(0, 99) < 15);
			end
			MODE_GIF: begin
				pick  = $urandom_range(0, 9);
				digit = (pick == 0) ? 8'($urandom) : (pick < 5) ? "7" : "9";
				build_gif(rand_size16(), rand_size16(), digit, $urandom_range(0, 99) < 15);
			end
			default: begin
				pick = $urandom_range(0, 99);
				flaw = (pick < 7) ? FLAW_SOI : (pick < 15) ? FLAW_LENGTH : FLAW_NONE;
				build_jpeg(rand_size16(), rand_size16(), frame_code(),
					$urandom_range(0, 4), flaw);
			end
		endcase
		if ($urandom_range(0, 99) < 10)
			send_stray($urandom_range(1, 3));
		if ($urandom_range(0, 99) < 15)
			trim_file($urandom_range(1, file_bytes.size()));
		send_file($urandom_range(0, 99) >= 8);
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		logic [1:0]  mode;
		logic [15:0] lim;
		int          phase_no;
		int          sizes_base;

		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// PNG: size extremes, bad signature, short file, abandoned file
		program_regs(MODE_PNG, BYTE_LIMIT_RESET);
		send_stray(2);
		build_png(32'hFFFF_0000, 32'h8000_FFFF, 1'b0);
		send_file(1'b1);
		build_png(32'h0001_FFFF, 32'h7FFF_0000, 1'b0);
		send_file(1'b1);
		build_png(rand_size32(), rand_size32(), 1'b1);
		send_file(1'b1);
		build_png(rand_size32(), rand_size32(), 1'b0);
		trim_file(20);
		send_file(1'b1);
		build_png(rand_size32(), rand_size32(), 1'b0);
		trim_file(10);
		send_file(1'b0);
		build_png(rand_size32(), rand_size32(), 1'b0);
		send_file(1'b1);
		settle();

		// GIF: both versions, bad version digit, short file
		program_regs(MODE_GIF, BYTE_LIMIT_RESET);
		build_gif(16'hFFFF, 16'h0000, "7", 1'b0);
		send_file(1'b1);
		build_gif(16'h0000, 16'hFFFF, "9", 1'b0);
		send_file(1'b1);
		build_gif(rand_size16(), rand_size16(), "8", 1'b0);
		send_file(1'b1);
		build_gif(rand_size16(), rand_size16(), "9", 1'b0);
		trim_file(8);
		send_file(1'b1);
		settle();

		// JPEG: marker walk, bad start of image, short lengths, cut off
		program_regs(MODE_JPEG, BYTE_LIMIT_RESET);
		build_jpeg(16'hFFFF, 16'h0000, 8'hC0, 6, FLAW_NONE);
		send_file(1'b1);
		build_jpeg(16'h0000, 16'hFFFF, 8'hCF, 6, FLAW_NONE);
		send_file(1'b1);
		build_jpeg(rand_size16(), rand_size16(), frame_code(), 2, FLAW_SOI);
		send_file(1'b1);
		build_jpeg(rand_size16(), rand_size16(), frame_code(), 3, FLAW_LENGTH);
		send_file(1'b1);
		build_jpeg(rand_size16(), rand_size16(), frame_code(), 3, FLAW_NONE);
		trim_file(file_bytes.size() - 3);
		send_file(1'b1);
		settle();

		// JPEG at the lowest limit: the frame lies beyond it
		program_regs(MODE_JPEG, 16'd16);
		build_jpeg(rand_size16(), rand_size16(), frame_code(), 8, FLAW_NONE);
		send_file(1'b1);
		settle();

		// Unused mode: rejected on the first byte, the rest dropped
		program_regs(MODE_UNUSED, BYTE_LIMIT_RESET);
		build_png(rand_size32(), rand_size32(), 1'b0);
		send_file(1'b1);
		settle();

		// Small limit: one maximal segment runs into it
		program_regs(MODE_JPEG, 16'd64);
		file_bytes = {JPG_FF, JPG_SOI, JPG_FF, 8'hE0, 8'hFF, 8'hFF};
		repeat (64)
			file_bytes.push_back(8'($urandom));
		send_file(1'b1);
		settle();

		// Random phases, one of them with no idling at all
		random_bytes = 0;
		sizes_base   = sizes_checked;
		phase_no     = 0;
		while (random_bytes < 1200 || sizes_checked < sizes_base + 48) begin
			calm = (phase_no == 2);
			mode = ($urandom_range(0, 9) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
			case ($urandom_range(0, 3))
				0:       lim = 16'd16;
				1:       lim = 16'($urandom_range(16, 300));
				2:       lim = BYTE_LIMIT_RESET;
				default: lim = 16'hFFFF;
			endcase
			program_regs(mode, lim);
			repeat (12)
				random_file();
			settle();
			phase_no++;
		end
		calm = 1'b0;

		if (sb.faults == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
